>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL; compiled out when ASSERT_OFF is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, sampled on clk, held off during reset.
`define ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: lbl");

// Next-cycle implication, sampled on clk, held off during reset.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: lbl");

`else

`define ASSERT_IMPLIES(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> rtl/gdcp_pkg.sv
// Package: widths, phase codes, character constants and the digit accumulate functions.
package gdcp_pkg;

    localparam int GUIDE_WIDTH    = 8;
    localparam int DISTANCE_WIDTH = 32;
    localparam int PHASE_W        = 3;

    localparam logic [PHASE_W-1:0] PH_WAIT_G  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_GUIDE   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_WAIT_D  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_DIST    = 3'd3;
    localparam logic [PHASE_W-1:0] PH_WAIT_NL = 3'd4;
    localparam logic [PHASE_W-1:0] PH_PENDING = 3'd5;

    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_CONSUME = 1'b1;

    localparam logic [7:0] CH_G       = 8'h67;
    localparam logic [7:0] CH_D       = 8'h64;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_ZERO    = 8'h30;

    typedef logic [GUIDE_WIDTH-1:0]    guide_t;
    typedef logic [DISTANCE_WIDTH-1:0] distance_t;

    // acc*10 + (byte - '0'), wrapping at the guide width
    function automatic guide_t guide_step(guide_t acc, logic [7:0] b);
        guide_t times_ten;
        guide_t digit;
        times_ten = (acc << 3) + (acc << 1);
        digit     = guide_t'(b) - guide_t'(CH_ZERO);
        return times_ten + digit;
    endfunction

    // acc*10 + (byte - '0'), wrapping at the distance width
    function automatic distance_t distance_step(distance_t acc, logic [7:0] b);
        distance_t times_ten;
        distance_t digit;
        times_ten = (acc << 3) + (acc << 1);
        digit     = distance_t'(b) - distance_t'(CH_ZERO);
        return times_ten + digit;
    endfunction

endpackage

>>> rtl/gdcp_if.sv
// Stream interfaces: command beats in, guide/distance result beats out.
interface gdcp_cmd_if
    import gdcp_pkg::*;
;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] rx_byte;

    modport source (output valid, output op, output rx_byte, input ready);
    modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

interface gdcp_result_if
    import gdcp_pkg::*;
;
    logic                             valid;
    logic                             ready;
    logic [GUIDE_WIDTH-1:0]           guide_code;
    logic signed [DISTANCE_WIDTH-1:0] distance_value;

    modport source (output valid, output guide_code, output distance_value, input ready);
    modport sink   (input valid, input guide_code, input distance_value, output ready);
endinterface

>>> rtl/guide_distance_command_parser_core.sv
// A consume beat waits in the input register until advance, then loads the result register.
// Throughput: one beat per cycle, byte or consume, while the result side keeps up.
// The input register and the result register are the only pipeline stages; the phase and
// both accumulators update in the second stage, so each beat sees the previous one's state.
// Reset (rst_n low, asynchronous): phase to wait-for-g, accumulators to zero, stages empty.
`include "assert_macros.svh"

module guide_distance_command_parser_core
    import gdcp_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    gdcp_cmd_if.sink        cmd,
    gdcp_result_if.source   result
);

    // Stage 1: registered input beat
    logic       in_valid_reg;
    logic       in_op_reg;
    logic [7:0] in_byte_reg;

    // Parser state
    logic [PHASE_W-1:0] phase_reg, phase_next;
    guide_t             guide_accum_reg, guide_accum_next;
    distance_t          distance_accum_reg, distance_accum_next;

    // Stage 2: result register
    logic      out_valid_reg, out_valid_next;
    guide_t    out_guide_reg;
    distance_t out_distance_reg;

    logic advance;   // stage 2 may take the stage 1 beat
    logic fire;      // stage 1 beat is processed this cycle
    logic emit;      // this beat produces a result
    logic byte_in_pending;   // a byte beat processed while a command is pending

    // Advance whenever the result register is free or being drained.
    assign advance   = !out_valid_reg || result.ready;
    assign fire      = in_valid_reg && advance;
    assign cmd.ready = !in_valid_reg || advance;
    assign emit      = fire && (in_op_reg == OP_CONSUME) && (phase_reg == PH_PENDING);
    assign byte_in_pending = fire && (in_op_reg == OP_BYTE) && (phase_reg == PH_PENDING);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            in_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ready && cmd.valid)
        begin
            in_op_reg   <= cmd.op;
            in_byte_reg <= cmd.rx_byte;
        end
    end

    // Parser next state: a consume only matters while pending; bytes walk the phases.
    always_comb
    begin
        phase_next          = phase_reg;
        guide_accum_next    = guide_accum_reg;
        distance_accum_next = distance_accum_reg;
        if (fire)
        begin
            if (in_op_reg == OP_CONSUME)
            begin
                if (phase_reg == PH_PENDING)
                begin
                    phase_next = PH_WAIT_G;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_WAIT_G:
                    begin
                        // Only 'g' clears; any first byte moves on to the guide field.
                        if (in_byte_reg == CH_G)
                        begin
                            guide_accum_next    = '0;
                            distance_accum_next = '0;
                        end
                        phase_next = PH_GUIDE;
                    end
                    PH_GUIDE:
                    begin
                        if (in_byte_reg == CH_SPACE)
                            phase_next = PH_WAIT_D;
                        else
                            guide_accum_next = guide_step(guide_accum_reg, in_byte_reg);
                    end
                    PH_WAIT_D:
                    begin
                        if (in_byte_reg == CH_D)
                            phase_next = PH_DIST;
                    end
                    PH_DIST:
                    begin
                        if (in_byte_reg == CH_SPACE)
                            phase_next = PH_WAIT_NL;
                        else
                            distance_accum_next = distance_step(distance_accum_reg, in_byte_reg);
                    end
                    PH_WAIT_NL:
                    begin
                        if (in_byte_reg == CH_NEWLINE)
                            phase_next = PH_PENDING;
                    end
                    default:
                    begin
                        // Pending and unused codes: drop the byte.
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    // Result register: load on emit, clear once taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_WAIT_G;
            guide_accum_reg    <= '0;
            distance_accum_reg <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            phase_reg          <= phase_next;
            guide_accum_reg    <= guide_accum_next;
            distance_accum_reg <= distance_accum_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_guide_reg    <= guide_accum_reg;
            out_distance_reg <= distance_accum_reg;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.guide_code     = out_guide_reg;
    assign result.distance_value = $signed(out_distance_reg);

    // Checks
    `ASSERT_IMPLIES(a_phase_legal, 1'b1, phase_reg <= PH_PENDING)
    `ASSERT_IMPLIES(a_rise_from_pending, $rose(out_valid_reg), $past(phase_reg) == PH_PENDING)
    `ASSERT_NEXT(a_emit_loads, emit, out_valid_reg && (phase_reg == PH_WAIT_G))
    `ASSERT_NEXT(a_pending_holds, byte_in_pending, (phase_reg == PH_PENDING) && $stable(guide_accum_reg))

endmodule

>>> tb/sv/testbench.sv
// Testbench for the guide/distance command parser: random command streams, predicted results.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import gdcp_pkg::*;

    // Random stimulus stops once this many beats have been accepted.
    localparam int unsigned BEAT_GOAL = 1350;
    // Hard ceiling on the run, far above the slowest legal run.
    localparam int unsigned CYCLE_LIMIT = 200000;
    // Settling margin after the last awaited result has been checked.
    localparam int unsigned DRAIN_CYCLES = 10;
    // Length of the deliberate result-side stall.
    localparam int unsigned HOLD_CYCLES = 240;

    typedef logic [7:0] octet_t;

    typedef struct packed {
        guide_t    guide;
        distance_t distance;
    } command_t;

    // Tracks the parser phase and both accumulators, and queues the commands it expects.
    class parser_scoreboard;
        logic [PHASE_W-1:0] phase;
        guide_t             guide_acc;
        distance_t          dist_acc;
        command_t           awaited[$];
        int unsigned        errors;

        function new();
            phase     = PH_WAIT_G;
            guide_acc = '0;
            dist_acc  = '0;
            errors    = 0;
        endfunction

        // Advance the parser state for one accepted beat.
        function void note_beat(logic op, octet_t b);
            if (op == OP_CONSUME) begin
                if (phase != PH_PENDING)
                    return;
                awaited.push_back('{guide: guide_acc, distance: dist_acc});
                phase = PH_WAIT_G;
                return;
            end
            case (phase)
                PH_WAIT_G:
                begin
                    // Only a 'g' clears the accumulators; any first byte moves on.
                    if (b == CH_G)
                    begin
                        guide_acc = '0;
                        dist_acc  = '0;
                    end
                    phase = PH_GUIDE;
                end
                PH_GUIDE:
                begin
                    if (b == CH_SPACE)
                        phase = PH_WAIT_D;
                    else
                        guide_acc = guide_t'(longint'(guide_acc) * 10
                                             + longint'(b) - longint'(CH_ZERO));
                end
                PH_WAIT_D:
                begin
                    if (b == CH_D)
                        phase = PH_DIST;
                end
                PH_DIST:
                begin
                    if (b == CH_SPACE)
                        phase = PH_WAIT_NL;
                    else
                        dist_acc = distance_t'(longint'(dist_acc) * 10
                                               + longint'(b) - longint'(CH_ZERO));
                end
                PH_WAIT_NL:
                begin
                    if (b == CH_NEWLINE)
                        phase = PH_PENDING;
                end
                default:
                    ;
            endcase
        endfunction

        task report(string what);
            errors++;
            $display("[%0t] MISMATCH: %s", $realtime, what);
        endtask

        // Compare one result beat with the oldest command waiting.
        task check_result(guide_t guide, distance_t distance);
            command_t want;
            if (awaited.size() == 0)
            begin
                report($sformatf("result with none pending: guide=%0d distance=%0d",
                                 guide, $signed(distance)));
                return;
            end
            want = awaited.pop_front();
            if (guide !== want.guide)
                report($sformatf("guide_code got %0d, want %0d", guide, want.guide));
            if (distance !== want.distance)
                report($sformatf("distance_value got %0d, want %0d",
                                 $signed(distance), $signed(want.distance)));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;

    gdcp_cmd_if    cmd_if ();
    gdcp_result_if res_if ();

    guide_distance_command_parser_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_if),
        .result (res_if)
    );

    parser_scoreboard sb = new();

    // quiet turns off random idling on both sides for a long stretch.
    bit          quiet = 1'b0;
    bit          hold_request = 1'b0;
    int unsigned hold_left = 0;
    int unsigned sent_beats = 0;
    int unsigned cycle_count = 0;

    always #4 clk = ~clk;

    // Drive one beat: idle at random, offer it, hold it until the parser takes it.
    // Valid stays high after acceptance; the next call decides whether to drop it.
    task automatic send_beat(logic op, octet_t b);
        while (!quiet && $urandom_range(0, 99) < 31)
        begin
            cmd_if.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_if.valid   <= 1'b1;
        cmd_if.op      <= op;
        cmd_if.rx_byte <= b;
        do
            @(posedge clk);
        while (cmd_if.ready !== 1'b1);
        sb.note_beat(op, b);
        sent_beats++;
    endtask

    // Field content: mostly decimal digits, now and then any byte but the terminator.
    function automatic octet_t field_char();
        octet_t c;
        if ($urandom_range(0, 99) < 90)
            return CH_ZERO + octet_t'($urandom_range(0, 9));
        do
            c = octet_t'($urandom_range(0, 255));
        while (c == CH_SPACE);
        return c;
    endfunction

    function automatic octet_t any_but(octet_t avoid);
        octet_t c;
        do
            c = octet_t'($urandom_range(0, 255));
        while (c == avoid);
        return c;
    endfunction

    // Build "g<digits> d<digits> <anything>\n" with random content and field lengths.
    // Long fields now and then push both accumulators well past their wrap point.
    task automatic build_command(output octet_t text[$]);
        text = {};
        text.push_back($urandom_range(0, 99) < 85 ? CH_G : octet_t'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 99) < 10 ? $urandom_range(4, 8) : $urandom_range(0, 3))
            text.push_back(field_char());
        text.push_back(CH_SPACE);
        repeat ($urandom_range(0, 99) < 20 ? $urandom_range(1, 3) : 0)
            text.push_back(any_but(CH_D));
        text.push_back(CH_D);
        repeat ($urandom_range(0, 99) < 15 ? $urandom_range(10, 14) : $urandom_range(0, 6))
            text.push_back(field_char());
        text.push_back(CH_SPACE);
        repeat ($urandom_range(0, 4))
            text.push_back(any_but(CH_NEWLINE));
        text.push_back(CH_NEWLINE);
    endtask

    // Send one command and consume it; a broken one is cut short and maybe consumed anyway.
    task automatic run_command(bit broken);
        octet_t text[$];
        int     cut;
        build_command(text);
        if (broken)
        begin
            cut  = $urandom_range(1, text.size() - 1);
            text = text[0:cut-1];
        end
        foreach (text[i])
            send_beat(OP_BYTE, text[i]);
        // Stray bytes after the newline land while the command is pending.
        if ($urandom_range(0, 99) < 15)
            repeat ($urandom_range(1, 3))
                send_beat(OP_BYTE, octet_t'($urandom_range(0, 255)));
        if (!broken || $urandom_range(0, 1) == 1)
            send_beat(OP_CONSUME, octet_t'($urandom_range(0, 255)));
    endtask

    // Drop valid and wait until every pending command has come out, then settle.
    task automatic wait_for_results();
        cmd_if.valid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    // Result side: check each accepted beat, then pick ready for the next edge.
    // A hold request stalls the result side so the parser backs up.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (res_if.valid === 1'b1 && res_if.ready === 1'b1)
                sb.check_result(res_if.guide_code, res_if.distance_value);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_if.ready <= 1'b0;
            end
            else
                res_if.ready <= quiet || $urandom_range(0, 99) >= 31;
        end
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        bit hold_done;
        bit pause_done;
        int pick;
        hold_done  = 1'b0;
        pause_done = 1'b0;

        rst_n          = 1'b0;
        cmd_if.valid   = 1'b0;
        cmd_if.op      = OP_BYTE;
        cmd_if.rx_byte = '0;
        res_if.ready   = 1'b0;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: consume with nothing pending, a first byte other than 'g' (keeps the
        // accumulators), an empty guide field, ignored bytes in wait-d, wait-newline and
        // pending, a non-digit that drives distance negative, and a guide that wraps.
        send_beat(OP_CONSUME, 8'hFF);
        send_beat(OP_BYTE, "x");
        send_beat(OP_BYTE, CH_SPACE);
        send_beat(OP_BYTE, 8'hFF);
        send_beat(OP_BYTE, CH_NEWLINE);
        send_beat(OP_BYTE, CH_D);
        send_beat(OP_BYTE, 8'h00);
        send_beat(OP_BYTE, CH_SPACE);
        send_beat(OP_BYTE, CH_G);
        send_beat(OP_BYTE, CH_NEWLINE);
        send_beat(OP_BYTE, CH_G);
        send_beat(OP_CONSUME, 8'h00);
        send_beat(OP_BYTE, CH_G);
        repeat (3)
            send_beat(OP_BYTE, CH_ZERO + 8'd9);
        send_beat(OP_BYTE, CH_SPACE);
        send_beat(OP_BYTE, CH_D);
        send_beat(OP_BYTE, CH_ZERO + 8'd9);
        send_beat(OP_BYTE, 8'hFF);
        send_beat(OP_BYTE, CH_SPACE);
        send_beat(OP_BYTE, CH_NEWLINE);
        send_beat(OP_CONSUME, 8'h55);
        send_beat(OP_CONSUME, 8'hAA);

        // Random: mostly well-formed commands, some cut short, some raw noise.
        while (sent_beats < BEAT_GOAL)
        begin
            quiet = (sent_beats >= 400 && sent_beats < 650);
            if (!hold_done && sent_beats >= 800)
            begin
                // Stall the result side while commands keep coming, so input backs up.
                hold_done    = 1'b1;
                hold_request = 1'b1;
                repeat (4)
                    run_command(1'b0);
            end
            if (!pause_done && sent_beats >= 1000)
            begin
                pause_done = 1'b1;
                wait_for_results();
            end
            pick = $urandom_range(0, 99);
            if (pick < 80)
                run_command(1'b0);
            else if (pick < 90)
                run_command(1'b1);
            else
                repeat ($urandom_range(1, 6))
                    send_beat($urandom_range(0, 99) < 20 ? OP_CONSUME : OP_BYTE,
                              octet_t'($urandom_range(0, 255)));
        end

        wait_for_results();
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> guide_distance_command_parser_core.f
+incdir+rtl
rtl/gdcp_pkg.sv
rtl/gdcp_if.sv
rtl/guide_distance_command_parser_core.sv
tb/sv/testbench.sv
